>>> sv/watchdog_timeout_select_unit_assert.svh
// Assertion macros for the watchdog timeout select unit.
// Included by watchdog_timeout_select_unit.sv; no other dependencies.
`ifndef WATCHDOG_TIMEOUT_SELECT_UNIT_ASSERT_SVH
`define WATCHDOG_TIMEOUT_SELECT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WTS_ASSERT(label, clk, rst, prop, msg)
`define WTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> sv/wts_pkg.sv
// Shared types, constants and functions of the watchdog timeout select unit.
// No dependencies.
`default_nettype none
package wts_pkg;
   localparam int unsigned NumDividers = 6;
   localparam int unsigned NumPeriods  = 4;
   localparam int unsigned TblDepth    = 16;   // distinct exponents 12..27
   localparam int unsigned NumBits     = 37;   // width of 1000 * 2^27
   localparam int unsigned TblFirstStep = 22;  // step that yields 1000*2^12/clk
   localparam logic [NumBits-1:0] Numer = NumBits'(1000) << 27;
   localparam logic [29:0] ClockReset = 30'd50000000;

   localparam logic [3:0] DivCode4    = 4'd1;
   localparam logic [3:0] DivCode64   = 4'd4;
   localparam logic [3:0] DivCode128  = 4'd15;
   localparam logic [3:0] DivCode512  = 4'd6;
   localparam logic [3:0] DivCode2048 = 4'd7;
   localparam logic [3:0] DivCode8192 = 4'd8;

   typedef logic [TblDepth-1:0][31:0] tbl_type;

   typedef struct packed {
      logic [31:0] req;
      logic [31:0] best;
      logic [2:0]  bd;
      logic [1:0]  bp;
   } search_type;

   function automatic logic [3:0] div_code(input logic [2:0] d);
      logic [3:0] c;
      unique case (d)
         3'd0:    c = DivCode4;
         3'd1:    c = DivCode64;
         3'd2:    c = DivCode128;
         3'd3:    c = DivCode512;
         3'd4:    c = DivCode2048;
         default: c = DivCode8192;
      endcase
      return c;
   endfunction

   // log2 of divider and of period, minus the table base exponent 12
   function automatic logic [3:0] pair_index(input logic [2:0] d, input logic [1:0] p);
      logic [4:0] dl;
      logic [4:0] pl;
      unique case (d)
         3'd0:    dl = 5'd2;
         3'd1:    dl = 5'd6;
         3'd2:    dl = 5'd7;
         3'd3:    dl = 5'd9;
         3'd4:    dl = 5'd11;
         default: dl = 5'd13;
      endcase
      unique case (p)
         2'd0:    pl = 5'd10;
         2'd1:    pl = 5'd12;
         2'd2:    pl = 5'd13;
         default: pl = 5'd14;
      endcase
      return 4'(dl + pl - 5'd12);
   endfunction
endpackage
`default_nettype wire

>>> sv/wts_divider.sv
// Clock register and bit-serial divider that fills the table of
// floor(1000 * 2^k / clock_hz), k = 12..27. Depends on wts_pkg.
`default_nettype none
module wts_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [29:0]       csr_wr_data,
   output logic                   busy,
   output logic                   clk_zero,
   output wts_pkg::tbl_type       tbl
);
   logic [29:0] clk_ff;
   logic        busy_ff;
   logic [5:0]  cnt_ff;
   logic [29:0] rem_ff;
   logic [31:0] quo_ff;
   wts_pkg::tbl_type tbl_ff;

   logic [5:0]  step_in;
   logic [30:0] r2;
   logic        take;
   logic [29:0] rem_in;
   logic [31:0] quo_in;
   logic [5:0]  slot;

   always_comb begin
      step_in = cnt_ff + 6'd1;
      r2      = {rem_ff, wts_pkg::Numer[6'(wts_pkg::NumBits - 1) - cnt_ff]};
      take    = r2 >= {1'b0, clk_ff};
      rem_in  = take ? 30'(r2 - {1'b0, clk_ff}) : r2[29:0];
      quo_in  = {quo_ff[30:0], take};
      slot    = step_in - 6'(wts_pkg::TblFirstStep);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff  <= wts_pkg::ClockReset;
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (csr_wr_en) begin
         clk_ff  <= csr_wr_data;
         busy_ff <= csr_wr_data != '0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= step_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         if (step_in >= 6'(wts_pkg::TblFirstStep)) begin
            tbl_ff[slot[3:0]] <= quo_in;
         end
         if (step_in == 6'(wts_pkg::NumBits)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign clk_zero = clk_ff == '0;
   assign tbl      = tbl_ff;
endmodule
`default_nettype wire

>>> sv/wts_search_stage.sv
// One pipeline stage of the pair search: the four periods of one divider.
// Depends on wts_pkg.
`default_nettype none
module wts_search_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [2:0]           div_index,
   input  wire wts_pkg::tbl_type     tbl,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire wts_pkg::search_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output wts_pkg::search_type       out_data
);
   logic                valid_ff;
   wts_pkg::search_type data_ff;
   wts_pkg::search_type data_in;
   logic [31:0]         t;

   always_comb begin
      data_in = in_data;
      t       = '0;
      for (int p = 0; p < wts_pkg::NumPeriods; p++) begin
         t = tbl[wts_pkg::pair_index(div_index, 2'(p))];
         if (t >= data_in.req && (data_in.best == '0 || t < data_in.best)) begin
            data_in.best = t;
            data_in.bd   = div_index;
            data_in.bp   = 2'(p);
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

>>> sv/watchdog_timeout_select_unit.sv
// Watchdog timeout select unit: picks divider and period for a requested
// timeout in ms. One request per cycle while req_ready is high; the pipe
// stalls while rsp_ready is low. Each request passes six search stages,
// one per divider, then the output register. After reset and after each
// clock_hz write, req_ready stays low while the bit-serial divider rebuilds
// its table of 16 timeouts (one quotient bit per cycle); a zero clock needs no table and answers error.
`default_nettype none
`include "watchdog_timeout_select_unit_assert.svh"
module watchdog_timeout_select_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [29:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_requested_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_error,
   output logic [31:0]      rsp_achieved_ms,
   output logic [1:0]       rsp_period_code,
   output logic [3:0]       rsp_divider_code
);
   logic             busy;
   logic             clk_zero;
   wts_pkg::tbl_type tbl;

   logic                stg_valid [wts_pkg::NumDividers+1];
   logic                stg_ready [wts_pkg::NumDividers+1];
   wts_pkg::search_type stg_data  [wts_pkg::NumDividers+1];

   logic        rsp_valid_ff;
   logic        rsp_error_ff;
   logic [31:0] rsp_ms_ff;
   logic [1:0]  rsp_p_ff;
   logic [3:0]  rsp_d_ff;

   logic        rsp_error_in;
   logic [31:0] rsp_ms_in;
   logic [1:0]  rsp_p_in;
   logic [3:0]  rsp_d_in;
   wts_pkg::search_type last;

   wts_divider u_div (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .busy, .clk_zero, .tbl
   );

   assign stg_valid[0]     = req_valid && !busy;
   assign req_ready        = stg_ready[0] && !busy;
   assign stg_data[0].req  = req_requested_ms;
   assign stg_data[0].best = '0;
   assign stg_data[0].bd   = '0;
   assign stg_data[0].bp   = '0;

   for (genvar d = 0; d < wts_pkg::NumDividers; d++) begin : g_stage
      wts_search_stage u_stage (
         .clock, .reset,
         .div_index (3'(d)),
         .tbl,
         .in_valid  (stg_valid[d]),
         .in_ready  (stg_ready[d]),
         .in_data   (stg_data[d]),
         .out_valid (stg_valid[d+1]),
         .out_ready (stg_ready[d+1]),
         .out_data  (stg_data[d+1])
      );
   end

   assign stg_ready[wts_pkg::NumDividers] = !rsp_valid_ff || rsp_ready;

   always_comb begin
      last         = stg_data[wts_pkg::NumDividers];
      rsp_error_in = clk_zero;
      rsp_ms_in    = last.best;
      rsp_p_in     = last.bp;
      rsp_d_in     = wts_pkg::div_code(last.bd);
      // nothing qualified: fall back to the largest pair
      if (last.best == '0) begin
         rsp_ms_in = tbl[wts_pkg::pair_index(3'(wts_pkg::NumDividers - 1),
                                             2'(wts_pkg::NumPeriods - 1))];
         rsp_p_in  = 2'(wts_pkg::NumPeriods - 1);
         rsp_d_in  = wts_pkg::div_code(3'(wts_pkg::NumDividers - 1));
      end
      if (clk_zero) begin
         rsp_ms_in = '0;
         rsp_p_in  = '0;
         rsp_d_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stg_ready[wts_pkg::NumDividers]) begin
         rsp_valid_ff <= stg_valid[wts_pkg::NumDividers];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[wts_pkg::NumDividers] && stg_valid[wts_pkg::NumDividers]) begin
         rsp_error_ff <= rsp_error_in;
         rsp_ms_ff    <= rsp_ms_in;
         rsp_p_ff     <= rsp_p_in;
         rsp_d_ff     <= rsp_d_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error        = rsp_error_ff;
   assign rsp_achieved_ms  = rsp_ms_ff;
   assign rsp_period_code  = rsp_p_ff;
   assign rsp_divider_code = rsp_d_ff;

   `WTS_ASSERT(a_err_zero_fields, clock, reset, rsp_valid && rsp_error |-> rsp_achieved_ms == '0 && rsp_period_code == '0 && rsp_divider_code == '0, "error response with nonzero fields")
   `WTS_ASSERT(a_csr_blocks_req, clock, reset, csr_wr_en && csr_wr_data != '0 |=> !req_ready, "request taken while table rebuilds")
   `WTS_ASSERT(a_div_code_legal, clock, reset, rsp_valid && !rsp_error |-> rsp_divider_code == wts_pkg::DivCode4 || rsp_divider_code == wts_pkg::DivCode64 || rsp_divider_code == wts_pkg::DivCode128 || rsp_divider_code == wts_pkg::DivCode512 || rsp_divider_code == wts_pkg::DivCode2048 || rsp_divider_code == wts_pkg::DivCode8192, "illegal divider code")
   `WTS_ASSERT_ALWAYS(a_reset_blocks_req, clock, reset |=> !req_ready, "request taken right after reset")
endmodule
`default_nettype wire
